>>> design/jtsp_pkg.sv
// ----------------------------------------------------------------------------
// jtsp_pkg
// Shared types, codes and helpers of the streaming json tokenizer.
// ----------------------------------------------------------------------------
package jtsp_pkg;

	localparam int TABLE_DEPTH_DEF   = 256;
	localparam int MAX_DOC_BYTES_DEF = 65536;
	localparam int LIMIT_W           = 9;
	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 9'd256;
	localparam int IN_Q_DEPTH        = 4;
	localparam int OUT_Q_DEPTH       = 4;
	localparam int MAX_RES           = 3;
	localparam int TDATA_W           = 72;

	// byte classes seen by the back end
	typedef enum logic [3:0] {
		CLS_OBJ_OPEN,
		CLS_ARR_OPEN,
		CLS_OBJ_CLOSE,
		CLS_ARR_CLOSE,
		CLS_QUOTE,
		CLS_BSLASH,
		CLS_SPACE,
		CLS_COMMA,
		CLS_COLON,
		CLS_OTHER
	} cls_t;

	typedef struct packed {
		cls_t cls;
		logic eod;
		logic too_long;
	} byte_info_t;

	typedef enum logic [1:0] {
		KIND_OBJECT,
		KIND_ARRAY,
		KIND_STRING,
		KIND_PRIM
	} tok_kind_t;

	typedef enum logic [2:0] {
		ST_OK,
		ST_BAD_CLOSER,
		ST_TABLE_FULL,
		ST_PARTIAL,
		ST_TOO_LONG
	} status_t;

	typedef enum logic [1:0] {
		MODE_GAP,
		MODE_STR,
		MODE_PRIM,
		MODE_SKIP
	} mode_t;

	typedef enum logic [0:0] {
		BK_RUN,
		BK_LOAD
	} back_state_t;

	// one result record
	typedef struct packed {
		logic              record_kind;
		logic [7:0]        token_index;
		logic [1:0]        token_kind;
		logic [15:0]       start_offset;
		logic [16:0]       end_offset;
		logic [7:0]        child_count;
		logic signed [8:0] parent_slot;
		logic [2:0]        doc_status;
		logic [8:0]        token_total;
		logic              run_last;
	} rec_t;

	// saturating child count increment
	function automatic logic [7:0] sat_inc8(input logic [7:0] v);
		sat_inc8 = (v == 8'hFF) ? v : v + 8'd1;
	endfunction

endpackage

>>> design/jtsp_fifo.sv
// ----------------------------------------------------------------------------
// jtsp_fifo
// Small register queue between the classifier front and the token back end.
// ----------------------------------------------------------------------------
module jtsp_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             pop,
	output logic [WIDTH-1:0] rd_data,
	output logic             full,
	output logic             empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full    = (count_q == CNT_W'(DEPTH));
	assign empty   = (count_q == '0);
	assign rd_data = mem_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

>>> design/jtsp_front.sv
// ----------------------------------------------------------------------------
// jtsp_front
// Input side: takes byte beats, classifies them and tags each with its
// offset in the document.
// ----------------------------------------------------------------------------
module jtsp_front import jtsp_pkg::*; #(
	parameter int MAX_DOC_BYTES = MAX_DOC_BYTES_DEF,
	parameter int POS_W         = 17
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [7:0]       s_tdata,   // text_byte
	input  logic             s_tlast,   // end_of_doc
	input  logic             q_full,
	output logic             q_push,
	output byte_info_t       q_info,
	output logic [POS_W-1:0] q_pos
);

	logic [POS_W-1:0] pos_q;
	logic             too_long;
	cls_t             cls;

	assign s_tready = !q_full;
	assign q_push   = s_tvalid && !q_full;
	assign too_long = (pos_q == POS_W'(MAX_DOC_BYTES));

	// byte classifier
	always_comb begin
		unique case (s_tdata)
			8'h7B:                      cls = CLS_OBJ_OPEN;
			8'h5B:                      cls = CLS_ARR_OPEN;
			8'h7D:                      cls = CLS_OBJ_CLOSE;
			8'h5D:                      cls = CLS_ARR_CLOSE;
			8'h22:                      cls = CLS_QUOTE;
			8'h5C:                      cls = CLS_BSLASH;
			8'h20, 8'h09, 8'h0D, 8'h0A: cls = CLS_SPACE;
			8'h2C:                      cls = CLS_COMMA;
			8'h3A:                      cls = CLS_COLON;
			default:                    cls = CLS_OTHER;
		endcase
	end

	assign q_info = '{cls: cls, eod: s_tlast, too_long: too_long};
	assign q_pos  = pos_q;

	// byte offset, restarts after the final beat of a document
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (q_push) begin
			if (s_tlast) begin
				pos_q <= '0;
			end else if (!too_long) begin
				pos_q <= pos_q + 1'b1;
			end
		end
	end

endmodule

>>> design/jtsp_back.sv
// ----------------------------------------------------------------------------
// jtsp_back
// Token back end: scan state, token allocation, open container cache and
// container table memory; produces up to three records per byte.
// ----------------------------------------------------------------------------
module jtsp_back import jtsp_pkg::*; #(
	parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
	parameter int POS_W       = 17,
	parameter int IDX_W       = 8,
	parameter int CNT_W       = 9
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [LIMIT_W-1:0] limit,
	input  logic               q_empty,
	input  byte_info_t         q_info,
	input  logic [POS_W-1:0]   q_pos,
	output logic               q_pop,
	input  logic               out_room,
	output logic [MAX_RES-1:0] res_vld,
	output rec_t               res [MAX_RES]
);

	typedef struct packed {
		logic             is_arr;
		logic [POS_W-1:0] start;
		logic [7:0]       child;
		logic             pvld;
		logic [IDX_W-1:0] pidx;
	} entry_t;

	entry_t mem_q [TABLE_DEPTH];
	entry_t rd_q;

	back_state_t      state_q, state_n;
	mode_t            mode_q, mode_n;
	logic [POS_W-1:0] pend_q, pend_n;
	logic             odd_q, odd_n;
	logic [CNT_W-1:0] used_q, used_n;
	logic             open_vld_q, open_vld_n;
	logic [IDX_W-1:0] open_idx_q, open_idx_n;
	entry_t           cache_q, cache_n;

	logic             go;
	logic [CNT_W-1:0] lim;
	logic [POS_W-1:0] pos1;
	logic             gap;
	logic             load;
	logic             clear;
	logic             mem_we;
	logic [IDX_W-1:0] mem_waddr;
	entry_t           mem_wdata;
	status_t          err;
	status_t          st;
	logic             delim;
	rec_t             r [MAX_RES];
	logic [MAX_RES-1:0] v;

	function automatic logic signed [8:0] par_of(input logic vld, input logic [IDX_W-1:0] idx);
		par_of = vld ? $signed(9'(idx)) : -9'sd1;
	endfunction

	function automatic rec_t mk_leaf(input logic [CNT_W-1:0] idx, input tok_kind_t kind,
			input logic [POS_W-1:0] st_off, input logic [POS_W-1:0] en_off,
			input logic pvld, input logic [IDX_W-1:0] pidx);
		rec_t x;
		x              = '0;
		x.token_index  = 8'(idx);
		x.token_kind   = kind;
		x.start_offset = 16'(st_off);
		x.end_offset   = 17'(en_off);
		x.parent_slot  = par_of(pvld, pidx);
		mk_leaf        = x;
	endfunction

	assign go    = (state_q == BK_RUN) && !q_empty && out_room;
	assign q_pop = go;
	assign pos1  = q_pos + 1'b1;
	assign lim   = (32'(limit) > 32'(TABLE_DEPTH)) ? CNT_W'(TABLE_DEPTH) : CNT_W'(limit);
	assign delim = (q_info.cls inside {CLS_COMMA, CLS_OBJ_CLOSE, CLS_ARR_CLOSE, CLS_SPACE});

	// per byte scan step
	always_comb begin
		state_n    = state_q;
		mode_n     = mode_q;
		pend_n     = pend_q;
		odd_n      = odd_q;
		used_n     = used_q;
		open_vld_n = open_vld_q;
		open_idx_n = open_idx_q;
		cache_n    = cache_q;
		err        = ST_OK;
		st         = ST_OK;
		gap        = 1'b0;
		load       = 1'b0;
		clear      = 1'b0;
		mem_we     = 1'b0;
		mem_waddr  = open_idx_q;
		mem_wdata  = cache_q;
		v          = '0;
		for (int i = 0; i < MAX_RES; i++) begin
			r[i] = '0;
		end

		if (state_q == BK_LOAD) begin
			cache_n = rd_q;
			state_n = BK_RUN;
		end else if (go) begin
			if (mode_q == MODE_SKIP) begin
				clear = q_info.eod;
			end else begin
				// string, primitive or gap handling
				if (q_info.too_long) begin
					err = ST_TOO_LONG;
				end else if (mode_q == MODE_STR) begin
					if (q_info.cls == CLS_QUOTE && !odd_q) begin
						mode_n = MODE_GAP;
						if (used_n >= lim) begin
							err = ST_TABLE_FULL;
						end else begin
							r[0] = mk_leaf(used_n, KIND_STRING, pend_q, q_pos,
								open_vld_n, open_idx_n);
							v[0] = 1'b1;
							if (open_vld_n) cache_n.child = sat_inc8(cache_n.child);
							used_n = used_n + 1'b1;
						end
					end else begin
						odd_n = (q_info.cls == CLS_BSLASH) ? !odd_q : 1'b0;
					end
				end else if (mode_q == MODE_PRIM) begin
					if (delim) begin
						mode_n = MODE_GAP;
						if (used_n >= lim) begin
							err = ST_TABLE_FULL;
						end else begin
							r[0] = mk_leaf(used_n, KIND_PRIM, pend_q, q_pos,
								open_vld_n, open_idx_n);
							v[0] = 1'b1;
							if (open_vld_n) cache_n.child = sat_inc8(cache_n.child);
							used_n = used_n + 1'b1;
							gap    = 1'b1;
						end
					end
				end else begin
					gap = 1'b1;
				end

				// byte between tokens
				if (gap) begin
					case (q_info.cls)
						CLS_OBJ_OPEN, CLS_ARR_OPEN: begin
							if (used_n >= lim) begin
								err = ST_TABLE_FULL;
							end else begin
								if (open_vld_n) begin
									mem_we          = 1'b1;
									mem_waddr       = open_idx_n;
									mem_wdata       = cache_n;
									mem_wdata.child = sat_inc8(cache_n.child);
								end
								cache_n.is_arr = (q_info.cls == CLS_ARR_OPEN);
								cache_n.start  = q_pos;
								cache_n.child  = '0;
								cache_n.pvld   = open_vld_n;
								cache_n.pidx   = open_idx_n;
								open_vld_n     = 1'b1;
								open_idx_n     = used_n[IDX_W-1:0];
								used_n         = used_n + 1'b1;
							end
						end
						CLS_OBJ_CLOSE, CLS_ARR_CLOSE: begin
							if (!open_vld_n || cache_n.is_arr != (q_info.cls == CLS_ARR_CLOSE)) begin
								err = ST_BAD_CLOSER;
							end else begin
								r[1].token_index  = 8'(open_idx_n);
								r[1].token_kind   = cache_n.is_arr ? KIND_ARRAY : KIND_OBJECT;
								r[1].start_offset = 16'(cache_n.start);
								r[1].end_offset   = 17'(pos1);
								r[1].child_count  = cache_n.child;
								r[1].parent_slot  = par_of(cache_n.pvld, cache_n.pidx);
								v[1]              = 1'b1;
								open_vld_n        = cache_n.pvld;
								open_idx_n        = cache_n.pidx;
								load              = cache_n.pvld;
							end
						end
						CLS_QUOTE: begin
							mode_n = MODE_STR;
							pend_n = pos1;
							odd_n  = 1'b0;
						end
						CLS_SPACE, CLS_COMMA, CLS_COLON: begin
						end
						default: begin
							mode_n = MODE_PRIM;
							pend_n = q_pos;
						end
					endcase
				end

				// document status
				if (err != ST_OK) begin
					r[2].record_kind = 1'b1;
					r[2].doc_status  = err;
					v[2]             = 1'b1;
					if (q_info.eod) begin
						clear = 1'b1;
					end else begin
						mode_n = MODE_SKIP;
					end
				end else if (q_info.eod) begin
					if (mode_n == MODE_PRIM) begin
						if (used_n >= lim) begin
							st = ST_TABLE_FULL;
						end else begin
							r[0] = mk_leaf(used_n, KIND_PRIM, pend_n, pos1,
								open_vld_n, open_idx_n);
							v[0] = 1'b1;
							used_n = used_n + 1'b1;
						end
					end
					if (st == ST_OK && (mode_n == MODE_STR || open_vld_n)) begin
						st = ST_PARTIAL;
					end
					r[2].record_kind = 1'b1;
					r[2].doc_status  = st;
					if (st == ST_OK) begin
						r[2].token_total = (32'(used_n) > 32'd511) ? 9'd511 : 9'(used_n);
					end
					v[2]  = 1'b1;
					clear = 1'b1;
				end
			end

			if (clear) begin
				used_n     = '0;
				open_vld_n = 1'b0;
				mode_n     = MODE_GAP;
				odd_n      = 1'b0;
				pend_n     = '0;
			end else if (load) begin
				state_n = BK_LOAD;
			end
		end

		// mark the last record of this byte
		if (v[2]) begin
			r[2].run_last = 1'b1;
		end else if (v[1]) begin
			r[1].run_last = 1'b1;
		end else if (v[0]) begin
			r[0].run_last = 1'b1;
		end
	end

	assign res_vld = v;
	always_comb begin
		for (int i = 0; i < MAX_RES; i++) begin
			res[i] = r[i];
		end
	end

	// container table, registered read of the enclosing container
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[mem_waddr] <= mem_wdata;
		end
		if (go && load) begin
			rd_q <= mem_q[cache_q.pidx];
		end
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= BK_RUN;
			mode_q     <= MODE_GAP;
			pend_q     <= '0;
			odd_q      <= 1'b0;
			used_q     <= '0;
			open_vld_q <= 1'b0;
			open_idx_q <= '0;
		end else begin
			state_q    <= state_n;
			mode_q     <= mode_n;
			pend_q     <= pend_n;
			odd_q      <= odd_n;
			used_q     <= used_n;
			open_vld_q <= open_vld_n;
			open_idx_q <= open_idx_n;
		end
	end

	// open container cache
	always_ff @(posedge clk) begin
		cache_q <= cache_n;
	end

endmodule

>>> design/jtsp_outq.sv
// ----------------------------------------------------------------------------
// jtsp_outq
// Result queue: takes up to three records a cycle, sends one beat a cycle while m_tready is high.
// ----------------------------------------------------------------------------
module jtsp_outq import jtsp_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [MAX_RES-1:0] res_vld,
	input  rec_t               res [MAX_RES],
	output logic               room,
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [TDATA_W-1:0] m_tdata,  // token_index, token_kind, start_offset, end_offset,
	                                     // child_count, parent_slot, doc_status, token_total
	output logic               m_tuser,  // record_kind
	output logic               m_tlast   // run_last
);

	localparam int PTR_W = $clog2(OUT_Q_DEPTH);
	localparam int CNT_W = $clog2(OUT_Q_DEPTH + 1);

	rec_t             mem_q [OUT_Q_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic [PTR_W-1:0] waddr [MAX_RES];
	logic [CNT_W-1:0] n_push;
	logic             pop;
	rec_t             head;

	assign room     = (count_q <= CNT_W'(OUT_Q_DEPTH - MAX_RES));
	assign m_tvalid = (count_q != '0);
	assign pop      = m_tvalid && m_tready;
	assign head     = mem_q[rd_ptr_q];

	// compact the valid records into consecutive slots
	always_comb begin
		n_push = '0;
		for (int i = 0; i < MAX_RES; i++) begin
			waddr[i] = wr_ptr_q + PTR_W'(n_push);
			n_push   = n_push + CNT_W'(res_vld[i]);
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < MAX_RES; i++) begin
			if (res_vld[i]) begin
				mem_q[waddr[i]] <= res[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + PTR_W'(n_push);
			rd_ptr_q <= rd_ptr_q + PTR_W'(pop);
			count_q  <= count_q + n_push - CNT_W'(pop);
		end
	end

	// beat packing, first field in the lowest bits
	assign m_tdata = {head.token_total, head.doc_status, head.parent_slot, head.child_count,
		head.end_offset, head.start_offset, head.token_kind, head.token_index};
	assign m_tuser = head.record_kind;
	assign m_tlast = head.run_last;

endmodule

>>> design/json_token_stream_parser.sv
// ----------------------------------------------------------------------------
// json_token_stream_parser
// Streaming JSON tokenizer: one byte beat in, token and status records out.
// ----------------------------------------------------------------------------
// The block takes one document byte per cycle into a four-entry queue while it
// is not full; the back end handles one byte per cycle while that queue holds
// a byte, except that a closing bracket whose container sits inside another is
// followed by a load step that reads the enclosing container's record from the
// table memory. Records leave one per cycle while m_tready is high, through a
// four-entry result queue, and a byte is handled only when that queue has room
// for the three records one byte can cause. A document's tokens are reported as
// they close; every document ends with one status record. No clearing pass after
// reset: the table is read only where it was written in the current document.
module json_token_stream_parser import jtsp_pkg::*; #(
	parameter int TABLE_DEPTH   = TABLE_DEPTH_DEF,
	parameter int MAX_DOC_BYTES = MAX_DOC_BYTES_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [7:0]         s_tdata,  // text_byte
	input  logic               s_tlast,  // end_of_doc
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [TDATA_W-1:0] m_tdata,  // token_index, token_kind, start_offset, end_offset,
	                                     // child_count, parent_slot, doc_status, token_total
	output logic               m_tuser,  // record_kind
	output logic               m_tlast,  // run_last
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [LIMIT_W-1:0] cfg_data  // token_limit
);

	localparam int POS_W  = $clog2(MAX_DOC_BYTES + 1);
	localparam int IDX_W  = $clog2(TABLE_DEPTH);
	localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
	localparam int INFO_W = $bits(byte_info_t);

	logic [LIMIT_W-1:0] limit_q;
	logic               q_full;
	logic               q_empty;
	logic               q_push;
	logic               q_pop;
	byte_info_t         f_info;
	logic [POS_W-1:0]   f_pos;
	logic [INFO_W+POS_W-1:0] q_rd;
	logic               out_room;
	logic [MAX_RES-1:0] res_vld;
	rec_t               res [MAX_RES];

	// token limit register
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_RESET;
		end else if (cfg_valid) begin
			limit_q <= cfg_data;
		end
	end

	jtsp_front #(
		.MAX_DOC_BYTES(MAX_DOC_BYTES),
		.POS_W        (POS_W)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tlast (s_tlast),
		.q_full  (q_full),
		.q_push  (q_push),
		.q_info  (f_info),
		.q_pos   (f_pos)
	);

	jtsp_fifo #(
		.WIDTH(INFO_W + POS_W),
		.DEPTH(IN_Q_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wr_data({f_info, f_pos}),
		.pop    (q_pop),
		.rd_data(q_rd),
		.full   (q_full),
		.empty  (q_empty)
	);

	jtsp_back #(
		.TABLE_DEPTH(TABLE_DEPTH),
		.POS_W      (POS_W),
		.IDX_W      (IDX_W),
		.CNT_W      (CNT_W)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.limit   (limit_q),
		.q_empty (q_empty),
		.q_info  (byte_info_t'(q_rd[INFO_W+POS_W-1:POS_W])),
		.q_pos   (q_rd[POS_W-1:0]),
		.q_pop   (q_pop),
		.out_room(out_room),
		.res_vld (res_vld),
		.res     (res)
	);

	jtsp_outq u_outq (
		.clk     (clk),
		.arst_n  (arst_n),
		.res_vld (res_vld),
		.res     (res),
		.room    (out_room),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser),
		.m_tlast (m_tlast)
	);

endmodule

>>> tb/sv/json_token_stream_parser_chk.sv
// ----------------------------------------------------------------------------
// json_token_stream_parser_chk
// Watches the byte, record and limit channels, predicts every token and
// status record of the tokenizer and compares them in order.
// ----------------------------------------------------------------------------
module json_token_stream_parser_chk import jtsp_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	input  logic               s_tready,
	input  logic [7:0]         s_tdata,
	input  logic               s_tlast,
	input  logic               m_tvalid,
	input  logic               m_tready,
	input  logic [TDATA_W-1:0] m_tdata,
	input  logic               m_tuser,
	input  logic               m_tlast,
	input  logic               cfg_valid,
	input  logic               cfg_ready,
	input  logic [LIMIT_W-1:0] cfg_data,
	output int                 fail_count,
	output int                 pending_records
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int DEPTH = TABLE_DEPTH_DEF;

	// tokenizer state mirrored here
	tok_kind_t         tbl_kind [DEPTH];
	logic [15:0]       tbl_start [DEPTH];
	logic [7:0]        tbl_children [DEPTH];
	logic signed [8:0] tbl_parent [DEPTH];
	int                used_slots;
	int                open_slot;
	mode_t             mode;
	logic [15:0]       str_start;
	int                offset;
	logic              odd_bs;
	logic [LIMIT_W-1:0] limit_reg;

	rec_t expected_records[$];
	rec_t step_recs[$];

	function automatic void push_rec(logic rk, logic [7:0] idx, logic [1:0] kind,
		logic [15:0] st, logic [16:0] en, logic [7:0] ch, logic signed [8:0] par,
		logic [2:0] status, logic [8:0] total);
		rec_t r;
		r = '0;
		r.record_kind = rk; r.token_index = idx; r.token_kind = kind;
		r.start_offset = st; r.end_offset = en; r.child_count = ch;
		r.parent_slot = par; r.doc_status = status; r.token_total = total;
		step_recs.push_back(r);
	endfunction

	function automatic void clear_doc();
		used_slots = 0;
		open_slot = -1;
		mode = MODE_GAP;
		str_start = '0;
		offset = 0;
		odd_bs = 1'b0;
	endfunction

	function automatic int alloc_slot(tok_kind_t kind, int st);
		int lim;
		int s;
		lim = (limit_reg > DEPTH) ? DEPTH : int'(limit_reg);
		s = used_slots;
		if (s >= lim) return -1;
		tbl_kind[s] = kind;
		tbl_start[s] = st[15:0];
		tbl_children[s] = '0;
		tbl_parent[s] = open_slot[8:0];
		if (open_slot >= 0 && tbl_children[open_slot] != 8'hFF)
			tbl_children[open_slot]++;
		used_slots = s + 1;
		return s;
	endfunction

	function automatic bit leaf(tok_kind_t kind, int st, int en);
		int s;
		s = alloc_slot(kind, st);
		if (s < 0) return 0;
		push_rec(1'b0, s[7:0], kind, st[15:0], en[16:0], '0, tbl_parent[s], ST_OK, '0);
		return 1;
	endfunction

	function automatic bit is_sep(logic [7:0] c);
		return c == " " || c == "\t" || c == 8'h0d || c == 8'h0a;
	endfunction

	function automatic status_t between_tokens(logic [7:0] c, int pos);
		int s;
		tok_kind_t want;
		if (c == "{" || c == "[") begin
			s = alloc_slot(c == "{" ? KIND_OBJECT : KIND_ARRAY, pos);
			if (s < 0) return ST_TABLE_FULL;
			open_slot = s;
		end else if (c == "}" || c == "]") begin
			want = (c == "}") ? KIND_OBJECT : KIND_ARRAY;
			if (open_slot < 0 || tbl_kind[open_slot] != want) return ST_BAD_CLOSER;
			push_rec(1'b0, open_slot[7:0], want, tbl_start[open_slot], 17'(pos + 1),
				tbl_children[open_slot], tbl_parent[open_slot], ST_OK, '0);
			open_slot = tbl_parent[open_slot];
		end else if (c == "\"") begin
			mode = MODE_STR;
			str_start = 16'(pos + 1);
			odd_bs = 1'b0;
		end else if (!(is_sep(c) || c == ":" || c == ",")) begin
			mode = MODE_PRIM;
			str_start = 16'(pos);
		end
		return ST_OK;
	endfunction

	// predict the records of one accepted byte
	function automatic void tokenize_byte(logic [7:0] c, logic eod);
		int pos;
		status_t err;
		status_t st;
		int total;
		pos = offset;
		err = ST_OK;
		step_recs.delete();
		if (mode == MODE_SKIP) begin
			if (eod) clear_doc();
			return;
		end
		if (pos >= MAX_DOC_BYTES_DEF) begin
			err = ST_TOO_LONG;
		end else if (mode == MODE_STR) begin
			if (c == "\"" && !odd_bs) begin
				mode = MODE_GAP;
				if (!leaf(KIND_STRING, str_start, pos)) err = ST_TABLE_FULL;
			end else begin
				odd_bs = (c == "\\") ? ~odd_bs : 1'b0;
			end
		end else if (mode == MODE_PRIM) begin
			if (is_sep(c) || c == "," || c == "}" || c == "]") begin
				mode = MODE_GAP;
				if (!leaf(KIND_PRIM, str_start, pos)) err = ST_TABLE_FULL;
				else err = between_tokens(c, pos);
			end
		end else begin
			err = between_tokens(c, pos);
		end
		offset = pos + 1;
		if (err != ST_OK) begin
			push_rec(1'b1, '0, '0, '0, '0, '0, '0, err, '0);
			if (eod) clear_doc();
			else mode = MODE_SKIP;
		end else if (eod) begin
			st = ST_OK;
			if (mode == MODE_PRIM && !leaf(KIND_PRIM, str_start, pos + 1))
				st = ST_TABLE_FULL;
			if (st == ST_OK && (mode == MODE_STR || open_slot >= 0))
				st = ST_PARTIAL;
			total = (st == ST_OK) ? ((used_slots > 511) ? 511 : used_slots) : 0;
			push_rec(1'b1, '0, '0, '0, '0, '0, '0, st, total[8:0]);
			clear_doc();
		end
		if (step_recs.size() > 0)
			step_recs[step_recs.size()-1].run_last = 1'b1;
		foreach (step_recs[i]) expected_records.push_back(step_recs[i]);
	endfunction

	assign pending_records = expected_records.size();

	// sample beats at the rising edge
	always @(posedge clk or negedge arst_n) begin
		rec_t got;
		rec_t want;
		if (!arst_n) begin
			clear_doc();
			limit_reg = LIMIT_RESET;
			expected_records.delete();
			fail_count = 0;
		end else begin
			if (cfg_valid && cfg_ready) limit_reg = cfg_data;
			if (s_tvalid && s_tready) tokenize_byte(s_tdata, s_tlast);
			if (m_tvalid && m_tready) begin
				// unpack the beat, first tdata field in the lowest bits
				got = '0;
				got.record_kind  = m_tuser;
				got.token_index  = m_tdata[7:0];
				got.token_kind   = m_tdata[9:8];
				got.start_offset = m_tdata[25:10];
				got.end_offset   = m_tdata[42:26];
				got.child_count  = m_tdata[50:43];
				got.parent_slot  = m_tdata[59:51];
				got.doc_status   = m_tdata[62:60];
				got.token_total  = m_tdata[71:63];
				got.run_last     = m_tlast;
				if (expected_records.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("unexpected record beat %h", got);
				end else begin
					want = expected_records.pop_front();
					if (got !== want) begin
						fail_count++;
						if (fail_count <= 10)
							$display("record mismatch: expected kind %0d idx %0d tk %0d st %0d en %0d ch %0d par %0d status %0d total %0d last %0d, got kind %0d idx %0d tk %0d st %0d en %0d ch %0d par %0d status %0d total %0d last %0d",
								want.record_kind, want.token_index, want.token_kind,
								want.start_offset, want.end_offset, want.child_count,
								want.parent_slot, want.doc_status, want.token_total,
								want.run_last, got.record_kind, got.token_index,
								got.token_kind, got.start_offset, got.end_offset,
								got.child_count, got.parent_slot, got.doc_status,
								got.token_total, got.run_last);
					end
				end
			end
		end
	end

endmodule

>>> tb/sv/json_token_stream_parser_tb.sv
// ----------------------------------------------------------------------------
// json_token_stream_parser_tb
// Feeds JSON documents byte by byte, directed then random well-formed and
// broken ones, under several table limits, with bursty input and a stalling
// record side; the checker predicts and compares every record.
// ----------------------------------------------------------------------------
module json_token_stream_parser_tb import jtsp_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	logic               clk;
	logic               arst_n;
	logic               s_tvalid;
	logic               s_tready;
	logic [7:0]         s_tdata;
	logic               s_tlast;
	logic               m_tvalid;
	logic               m_tready;
	logic [TDATA_W-1:0] m_tdata;
	logic               m_tuser;
	logic               m_tlast;
	logic               cfg_valid;
	logic               cfg_ready;
	logic [LIMIT_W-1:0] cfg_data;
	int                 fail_count;
	int                 pending_records;
	int                 hold_cycles;
	bit                 stim_done;
	byte unsigned       doc_text[$];

	json_token_stream_parser dut (.*);

	json_token_stream_parser_chk chk (.*);

	always begin
		clk = 1'b1; #5;
		clk = 1'b0; #5;
	end

	// receiver: random stalls, and a long hold when asked
	initial begin
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_cycles > 0) begin
				hold_cycles--;
				m_tready <= 1'b0;
			end else if (($urandom_range(0, 63) < 16) || stim_done)
				m_tready <= 1'b1;
			else
				m_tready <= $urandom_range(0, 3) != 0;
		end
	end

	// send one document with bursty valid
	task automatic send_doc();
		int burst;
		int gap;
		burst = 0;
		foreach (doc_text[i]) begin
			if (burst == 0) begin
				// the first beat of a document always follows an idle gap
				gap = $urandom_range((i == 0) ? 1 : 0, 4);
				if (i != 0 && gap > 0) s_tvalid <= 1'b0;
				repeat (gap) @(negedge clk);
				burst = $urandom_range(1, 12);
			end
			s_tvalid <= 1'b1;
			s_tdata <= doc_text[i];
			s_tlast <= (i == doc_text.size() - 1);
			@(posedge clk);
			while (!s_tready) @(posedge clk);
			@(negedge clk);
			burst--;
		end
		s_tvalid <= 1'b0;
		doc_text.delete();
	endtask

	task automatic add_str(string t);
		foreach (t[i]) doc_text.push_back(t[i]);
	endtask

	task automatic send_text(string t);
		add_str(t);
		send_doc();
	endtask

	task automatic wait_idle();
		while (pending_records != 0) @(negedge clk);
		repeat (20) @(negedge clk);
	endtask

	task automatic set_limit(int v);
		wait_idle();
		cfg_data <= v[LIMIT_W-1:0];
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// random value, mostly well formed
	task automatic gen_value(int depth);
		int n;
		int pick;
		string alpha;
		alpha = "ab\\\"x";
		pick = (depth > 3) ? $urandom_range(2, 3) : $urandom_range(0, 3);
		case (pick)
			0, 1: begin
				doc_text.push_back(pick == 0 ? "{" : "[");
				n = $urandom_range(0, 3);
				for (int k = 0; k < n; k++) begin
					if (k > 0) doc_text.push_back(",");
					if ($urandom_range(0, 3) == 0) doc_text.push_back(" ");
					if (pick == 0) begin
						add_str("\"k\":");
					end
					gen_value(depth + 1);
				end
				doc_text.push_back(pick == 0 ? "}" : "]");
			end
			2: begin
				doc_text.push_back("\"");
				n = $urandom_range(0, 4);
				repeat (n) doc_text.push_back(alpha[$urandom_range(0, 4)]);
				if (doc_text[$] == "\\") doc_text.push_back("n");
				doc_text.push_back("\"");
			end
			default: begin
				n = $urandom_range(1, 3);
				repeat (n) doc_text.push_back(8'($urandom_range(33, 126)) == "\""
					? 8'h31 : 8'($urandom_range(48, 57)));
				if ($urandom_range(0, 5) == 0) doc_text.push_back(8'($urandom_range(128, 255)));
			end
		endcase
	endtask

	initial begin
		int sent;
		int roll;
		int cut;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tlast = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		hold_cycles = 0;
		stim_done = 0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed documents: containers, escapes, errors, extremes
		send_text("{\"a\":[1,tr],\"b\\\"\":{}}");
		send_text("[\"x\\\\\",-5 \t\r\n]");
		send_text("]");
		send_text("[}abc");
		send_text("{\"un");
		send_text("7");
		doc_text.push_back(8'hFF); doc_text.push_back(8'h00); send_doc();
		set_limit(2);
		send_text("[1,2,3]");
		set_limit(0);
		send_text("\"s\"");
		set_limit(511);
		// long hold while input keeps coming
		hold_cycles = 60;
		send_text("[1,2,3,4,5,6,7,8,9,0]");
		set_limit(1);
		send_text("x");
		set_limit(256);

		// random documents, limits varied between phases
		sent = 0;
		while (sent < 270) begin
			if ($urandom_range(0, 9) == 0) begin
				roll = $urandom_range(0, 3);
				set_limit(roll == 0 ? 1 : roll == 1 ? $urandom_range(2, 6) :
					roll == 2 ? 256 : $urandom_range(257, 511));
			end
			gen_value(0);
			roll = $urandom_range(0, 9);
			if (roll == 0) begin
				cut = $urandom_range(0, doc_text.size() - 1);
				while (doc_text.size() > cut + 1) void'(doc_text.pop_back());
			end else if (roll == 1) begin
				doc_text.insert($urandom_range(0, doc_text.size()),
					8'($urandom_range(0, 255)));
			end
			sent += doc_text.size();
			send_doc();
		end
		wait_idle();
		stim_done = 1;
		repeat (50) @(negedge clk);
		if (fail_count == 0 && pending_records == 0)
			$display("json_token_stream_parser verification clean");
		else
			$display("json_token_stream_parser verification failed");
		$finish;
	end

	initial begin
		#20ms;
		$display("json_token_stream_parser verification failed");
		$finish;
	end

endmodule

>>> filelist.f
design/jtsp_pkg.sv
design/jtsp_fifo.sv
design/jtsp_front.sv
design/jtsp_back.sv
design/jtsp_outq.sv
design/json_token_stream_parser.sv
tb/sv/json_token_stream_parser_chk.sv
tb/sv/json_token_stream_parser_tb.sv
